@@ design/cddw_pkg.sv @@
// ----------------------------------------------------------------------------
// cddw_pkg
// Types and constants shared by the detune and drift walk unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cddw_pkg;

  localparam int CV_W   = 24;
  localparam int POS_W  = 32;
  localparam int SLP_W  = 16;
  localparam int GAIN_W = 16;
  localparam int CFG_W  = 32;
  localparam int IDX_W  = 3;

  localparam logic [IDX_W-1:0] REG_BYPASS     = 3'd0;
  localparam logic [IDX_W-1:0] REG_DT_GAIN    = 3'd1;
  localparam logic [IDX_W-1:0] REG_DR_GAIN    = 3'd2;
  localparam logic [IDX_W-1:0] REG_DT_STEP    = 3'd3;
  localparam logic [IDX_W-1:0] REG_DR_STEP    = 3'd4;
  localparam logic [IDX_W-1:0] REG_DT_PERIOD  = 3'd5;
  localparam logic [IDX_W-1:0] REG_DR_PERIOD  = 3'd6;

  localparam logic signed [33:0] POS_ONE  = 34'sh040000000;
  localparam logic signed [33:0] POS_MONE = -34'sh040000000;
  localparam logic signed [SLP_W-1:0] SLP_ONE  = 16'sd16384;
  localparam logic signed [SLP_W-1:0] SLP_MONE = -16'sd16384;
  localparam logic [31:0] LFSR_TAPS = 32'h80200003;
  localparam logic [31:0] LFSR_SEED = 32'hACE1ACE1;
  localparam logic signed [26:0] CV_MAX = 27'sd8388607;
  localparam logic signed [26:0] CV_MIN = -27'sd8388608;

  typedef enum logic [1:0] {
    CMD_PASS,
    CMD_PROC,
    CMD_AUTO
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t               kind;
    logic [1:0]              port;
    logic [3:0]              voice;
    logic signed [CV_W-1:0]  cv;
  } cmd_t;

  typedef struct packed {
    logic                    bypass;
    logic [GAIN_W-1:0]       dt_gain;
    logic [GAIN_W-1:0]       dr_gain;
    logic [31:0]             dt_step;
    logic [31:0]             dr_step;
    logic [31:0]             dt_period;
    logic [31:0]             dr_period;
  } cfg_t;

  typedef struct packed {
    logic                    valid;
    cmd_t                    cmd;
  } head_t;

  typedef struct packed {
    logic                    pop;
    logic                    clr_busy;
  } back_stat_t;

endpackage

`default_nettype wire

@@ design/cddw_in_if.sv @@
// ----------------------------------------------------------------------------
// cddw_in_if
// Sample request channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface cddw_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic [1:0]         out_port;
  logic [3:0]         voice_index;
  logic signed [23:0] cv_in;

  modport source (output valid, func, out_port, voice_index, cv_in, input ready);
  modport sink (input valid, func, out_port, voice_index, cv_in, output ready);
endinterface

`default_nettype wire

@@ design/cddw_out_if.sv @@
// ----------------------------------------------------------------------------
// cddw_out_if
// Result channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface cddw_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] cv_out;

  modport source (output valid, cv_out, input ready);
  modport sink (input valid, cv_out, output ready);
endinterface

`default_nettype wire

@@ design/cddw_front.sv @@
// ----------------------------------------------------------------------------
// cddw_front
// Accepts requests, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module cddw_front import cddw_pkg::*; #(
  parameter int POLY = 16,
  parameter int OUTS = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        func,
  input  wire logic [1:0]  out_port,
  input  wire logic [3:0]  voice_index,
  input  wire logic signed [CV_W-1:0] cv_in,
  input  wire logic        bypass,
  input  back_stat_t       stat,
  output head_t            head
);

  cmd_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  cmd_t       cmd;
  logic       push;

  always_comb begin
    cmd.port  = out_port;
    cmd.voice = voice_index;
    cmd.cv    = cv_in;
    if (func) begin
      cmd.kind = CMD_AUTO;
    end else if (bypass || int'(out_port) >= OUTS || int'(voice_index) >= POLY) begin
      cmd.kind = CMD_PASS;
    end else begin
      cmd.kind = CMD_PROC;
    end
  end

  assign in_ready   = (cnt_r != 2'd2) && !stat.clr_busy;
  assign push       = in_valid && in_ready;
  assign head.valid = (cnt_r != 2'd0);
  assign head.cmd   = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (stat.pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(stat.pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= cmd;
    end
  end

endmodule

`default_nettype wire

@@ design/cddw_back.sv @@
// ----------------------------------------------------------------------------
// cddw_back
// Executes queued requests: walk update, output sum, sweeps over the walk
// memories for clearing, autotune and slope redraws.
// ----------------------------------------------------------------------------
`default_nettype none

module cddw_back import cddw_pkg::*; #(
  parameter int POLY = 16,
  parameter int OUTS = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  cfg_t             cfg,
  input  head_t            head,
  output back_stat_t       stat,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic signed [CV_W-1:0] cv_out
);

  localparam int DR_N  = OUTS * POLY;
  localparam int AW_DT = (POLY > 1) ? $clog2(POLY) : 1;
  localparam int AW_DR = (DR_N > 1) ? $clog2(DR_N) : 1;
  localparam logic [AW_DR-1:0] DR_LAST = AW_DR'(DR_N - 1);
  localparam logic [AW_DR-1:0] DT_LAST = AW_DR'(POLY - 1);

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_MUL, S_ADD, S_ZERO, S_RDT, S_RDR
  } state_t;

  state_t state_r;
  logic [AW_DR-1:0] sweep_r;
  logic [31:0] lfsr_r, dt_evt_r, dr_evt_r;
  logic pend_dr_r;
  logic out_valid_r;
  logic signed [CV_W-1:0] out_cv_r;
  logic signed [CV_W-1:0] cv_r;
  logic [AW_DT-1:0] v_r;
  logic [AW_DR-1:0] k_r;

  logic signed [POS_W-1:0] dt_pos_m [POLY];
  logic signed [SLP_W-1:0] dt_slp_m [POLY];
  logic signed [POS_W-1:0] dr_pos_m [DR_N];
  logic signed [SLP_W-1:0] dr_slp_m [DR_N];
  logic signed [POS_W-1:0] dt_pos_q, dr_pos_q;
  logic signed [SLP_W-1:0] dt_slp_q, dr_slp_q;

  logic signed [POS_W-1:0] dpos_r, rpb_r;
  logic signed [SLP_W-1:0] dslp_r, rsb_r;
  logic [47:0] off_dt_r, off_dr_r, inc_dt_r, inc_dr_r;
  logic off_dt_neg_r, off_dr_neg_r, inc_dt_neg_r, inc_dr_neg_r;

  logic [AW_DT-1:0] dt_ra;
  logic [AW_DR-1:0] dr_ra;
  logic dt_pos_we, dt_slp_we, dr_pos_we, dr_slp_we;
  logic [AW_DT-1:0] dt_wa;
  logic [AW_DR-1:0] dr_wa;
  logic signed [POS_W-1:0] dt_pos_wd, dr_pos_wd;
  logic signed [SLP_W-1:0] dt_slp_wd, dr_slp_wd;

  logic [31:0] lfsr_nx;
  logic signed [SLP_W-1:0] draw;
  logic signed [33:0] rp_in;
  logic signed [POS_W-1:0] rpb;
  logic signed [SLP_W-1:0] rsb;
  logic [POS_W-1:0] dmag, rmag;
  logic [SLP_W-1:0] dsmag, rsmag;
  logic signed [26:0] off_dt, off_dr, sum;
  logic signed [CV_W-1:0] sat;
  logic signed [33:0] inc_dt, inc_dr, dp, rp;
  logic signed [POS_W-1:0] dp_b;
  logic signed [SLP_W-1:0] ds_b;
  logic [31:0] dt_evt_n, dr_evt_n;
  logic dt_hit, dr_hit, out_free;

  assign out_valid     = out_valid_r;
  assign cv_out        = out_cv_r;
  assign out_free      = !out_valid_r || out_ready;

  assign dt_ra = AW_DT'(head.cmd.voice);
  assign dr_ra = AW_DR'(int'(head.cmd.port) * POLY + int'(head.cmd.voice));

  // slope draw
  assign lfsr_nx = (lfsr_r >> 1) ^ (lfsr_r[0] ? LFSR_TAPS : 32'd0);
  assign draw    = $signed({1'b0, lfsr_nx[14:0]}) - SLP_ONE;

  // mul stage: drift bounces before its step
  always_comb begin
    rp_in = 34'(dr_pos_q);
    rpb   = dr_pos_q;
    rsb   = dr_slp_q;
    if (rp_in > POS_ONE) begin
      rpb = POS_W'(POS_ONE);
      rsb = SLP_MONE;
    end else if (rp_in < POS_MONE) begin
      rpb = POS_W'(POS_MONE);
      rsb = SLP_ONE;
    end
    dmag  = dt_pos_q[POS_W-1] ? POS_W'(-dt_pos_q) : POS_W'(dt_pos_q);
    rmag  = dr_pos_q[POS_W-1] ? POS_W'(-dr_pos_q) : POS_W'(dr_pos_q);
    dsmag = dt_slp_q[SLP_W-1] ? SLP_W'(-dt_slp_q) : SLP_W'(dt_slp_q);
    rsmag = rsb[SLP_W-1] ? SLP_W'(-rsb) : SLP_W'(rsb);
  end

  // add stage
  always_comb begin
    off_dt = $signed({5'd0, off_dt_r[47:26]});
    off_dr = $signed({5'd0, off_dr_r[47:26]});
    if (off_dt_neg_r) off_dt = -off_dt;
    if (off_dr_neg_r) off_dr = -off_dr;
    sum = 27'(cv_r) + off_dt + off_dr;
    if (sum > CV_MAX) begin
      sat = CV_W'(CV_MAX);
    end else if (sum < CV_MIN) begin
      sat = CV_W'(CV_MIN);
    end else begin
      sat = CV_W'(sum);
    end
    inc_dt = $signed({2'd0, inc_dt_r[47:16]});
    inc_dr = $signed({2'd0, inc_dr_r[47:16]});
    if (inc_dt_neg_r) inc_dt = -inc_dt;
    if (inc_dr_neg_r) inc_dr = -inc_dr;
    dp   = 34'(dpos_r) + inc_dt;
    rp   = 34'(rpb_r) + inc_dr;
    dp_b = POS_W'(dp);
    ds_b = dslp_r;
    if (dp > POS_ONE) begin
      dp_b = POS_W'(POS_ONE);
      ds_b = SLP_MONE;
    end else if (dp < POS_MONE) begin
      dp_b = POS_W'(POS_MONE);
      ds_b = SLP_ONE;
    end
    dt_evt_n = dt_evt_r + 32'd1;
    dr_evt_n = dr_evt_r + 32'd1;
    dt_hit   = dt_evt_n > cfg.dt_period;
    dr_hit   = dr_evt_n > cfg.dr_period;
  end

  // memory write selection
  always_comb begin
    dt_pos_we = 1'b0;
    dt_slp_we = 1'b0;
    dr_pos_we = 1'b0;
    dr_slp_we = 1'b0;
    dt_wa     = sweep_r[AW_DT-1:0];
    dr_wa     = sweep_r;
    dt_pos_wd = '0;
    dt_slp_wd = '0;
    dr_pos_wd = '0;
    dr_slp_wd = draw;
    case (state_r)
      S_CLR: begin
        dt_pos_we = (sweep_r <= DT_LAST);
        dt_slp_we = (sweep_r <= DT_LAST);
        dr_pos_we = 1'b1;
        dr_slp_we = 1'b1;
        dr_slp_wd = '0;
      end
      S_ZERO: begin
        dt_pos_we = (sweep_r <= DT_LAST);
        dr_pos_we = 1'b1;
      end
      S_RDT: begin
        dt_slp_we = 1'b1;
        dt_slp_wd = draw;
      end
      S_RDR: begin
        dr_slp_we = 1'b1;
      end
      S_ADD: begin
        dt_pos_we = 1'b1;
        dt_slp_we = 1'b1;
        dr_pos_we = 1'b1;
        dr_slp_we = 1'b1;
        dt_wa     = v_r;
        dr_wa     = k_r;
        dt_pos_wd = dp_b;
        dt_slp_wd = ds_b;
        dr_pos_wd = POS_W'(rp);
        dr_slp_wd = rsb_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (dt_pos_we) dt_pos_m[dt_wa] <= dt_pos_wd;
    if (dt_slp_we) dt_slp_m[dt_wa] <= dt_slp_wd;
    if (dr_pos_we) dr_pos_m[dr_wa] <= dr_pos_wd;
    if (dr_slp_we) dr_slp_m[dr_wa] <= dr_slp_wd;
    dt_pos_q <= dt_pos_m[dt_ra];
    dt_slp_q <= dt_slp_m[dt_ra];
    dr_pos_q <= dr_pos_m[dr_ra];
    dr_slp_q <= dr_slp_m[dr_ra];
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE) begin
      cv_r <= head.cmd.cv;
      v_r  <= dt_ra;
      k_r  <= dr_ra;
    end
    if (state_r == S_MUL) begin
      dpos_r       <= dt_pos_q;
      dslp_r       <= dt_slp_q;
      rpb_r        <= rpb;
      rsb_r        <= rsb;
      off_dt_r     <= 48'(cfg.dt_gain) * 48'(dmag);
      off_dr_r     <= 48'(cfg.dr_gain) * 48'(rmag);
      inc_dt_r     <= 48'(cfg.dt_step) * 48'(dsmag);
      inc_dr_r     <= 48'(cfg.dr_step) * 48'(rsmag);
      off_dt_neg_r <= dt_pos_q[POS_W-1];
      off_dr_neg_r <= dr_pos_q[POS_W-1];
      inc_dt_neg_r <= dt_slp_q[SLP_W-1];
      inc_dr_neg_r <= rsb[SLP_W-1];
    end
  end

  always_comb begin
    stat.clr_busy = (state_r == S_CLR);
    stat.pop      = 1'b0;
    if (state_r == S_IDLE && head.valid) begin
      case (head.cmd.kind)
        CMD_AUTO: stat.pop = 1'b1;
        CMD_PASS, CMD_PROC: stat.pop = out_free;
        default: stat.pop = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      sweep_r     <= '0;
      lfsr_r      <= LFSR_SEED;
      dt_evt_r    <= '0;
      dr_evt_r    <= '0;
      pend_dr_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLR, S_ZERO: begin
          sweep_r <= sweep_r + 1'b1;
          if (sweep_r == DR_LAST) begin
            sweep_r <= '0;
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (stat.pop) begin
            case (head.cmd.kind)
              CMD_AUTO: state_r <= S_ZERO;
              CMD_PASS: begin
                out_valid_r <= 1'b1;
                out_cv_r    <= head.cmd.cv;
              end
              default: state_r <= S_MUL;
            endcase
          end
        end
        S_MUL: state_r <= S_ADD;
        S_ADD: begin
          out_valid_r <= 1'b1;
          out_cv_r    <= sat;
          dt_evt_r    <= dt_hit ? 32'd0 : dt_evt_n;
          dr_evt_r    <= dr_hit ? 32'd0 : dr_evt_n;
          pend_dr_r   <= dr_hit;
          sweep_r     <= '0;
          if (dt_hit) begin
            state_r <= S_RDT;
          end else if (dr_hit) begin
            state_r <= S_RDR;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_RDT: begin
          lfsr_r  <= lfsr_nx;
          sweep_r <= sweep_r + 1'b1;
          if (sweep_r == DT_LAST) begin
            sweep_r <= '0;
            state_r <= pend_dr_r ? S_RDR : S_IDLE;
          end
        end
        S_RDR: begin
          lfsr_r  <= lfsr_nx;
          sweep_r <= sweep_r + 1'b1;
          if (sweep_r == DR_LAST) begin
            sweep_r <= '0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ design/cv_detune_drift_walk_unit.sv @@
// ----------------------------------------------------------------------------
// cv_detune_drift_walk_unit
// Adds per-voice detune and per-port/voice drift random walks to CV samples.
//
//   channel   dir  handshake        payload
//   in_ch     in   valid/ready      func, out_port, voice_index, cv_in
//   out_ch    out  valid/ready      cv_out
//   cfg_*     in   cfg_we           cfg_idx, cfg_data
//
// a sample passes the back end as memory read, then multiply, then add
// a detune redraw sweeps the POLY detune slopes, a drift redraw the OUTS*POLY drift slopes
// autotune sweeps the position memories
// after reset a clearing pass over the walk memories holds in_ch.ready low
// a two-entry queue decouples request intake from execution
// ----------------------------------------------------------------------------
`default_nettype none

module cv_detune_drift_walk_unit import cddw_pkg::*; #(
  parameter int POLY = 16,
  parameter int OUTS = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  cddw_in_if.sink                in_ch,
  cddw_out_if.source             out_ch,
  input  wire logic              cfg_we,
  input  wire logic [IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_W-1:0]  cfg_data
);

  cfg_t       cfg_r;
  head_t      head;
  back_stat_t stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bypass    <= 1'b0;
      cfg_r.dt_gain   <= 16'd328;
      cfg_r.dr_gain   <= 16'd328;
      cfg_r.dt_step   <= 32'd973;
      cfg_r.dr_step   <= 32'd973;
      cfg_r.dt_period <= 32'd2822400;
      cfg_r.dr_period <= 32'd940800;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_BYPASS:    cfg_r.bypass    <= cfg_data[0];
        REG_DT_GAIN:   cfg_r.dt_gain   <= cfg_data[GAIN_W-1:0];
        REG_DR_GAIN:   cfg_r.dr_gain   <= cfg_data[GAIN_W-1:0];
        REG_DT_STEP:   cfg_r.dt_step   <= cfg_data;
        REG_DR_STEP:   cfg_r.dr_step   <= cfg_data;
        REG_DT_PERIOD: cfg_r.dt_period <= cfg_data;
        REG_DR_PERIOD: cfg_r.dr_period <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  cddw_front #(.POLY(POLY), .OUTS(OUTS)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .func        (in_ch.func),
    .out_port    (in_ch.out_port),
    .voice_index (in_ch.voice_index),
    .cv_in       (in_ch.cv_in),
    .bypass      (cfg_r.bypass),
    .stat        (stat),
    .head        (head)
  );

  cddw_back #(.POLY(POLY), .OUTS(OUTS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .head      (head),
    .stat      (stat),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cv_out    (out_ch.cv_out)
  );

endmodule

`default_nettype wire

@@ bench/cv_detune_drift_walk_unit_tb.sv @@
// ----------------------------------------------------------------------------
// cv_detune_drift_walk_unit_tb
// Drives sample and autotune requests through the walk unit under several
// register settings and random backpressure, and checks every cv_out against
// the directed table or a cycle-free predictor of the detune and drift walks.
// ----------------------------------------------------------------------------
`default_nettype none

module cv_detune_drift_walk_unit_tb;
  import cddw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int POLY = 16;
  localparam int OUTS = 4;
  localparam int LIMIT = 2000000;
  localparam int SETTLE = 200;
  localparam logic [IDX_W-1:0] REG_NONE = 3'd7;
  localparam logic FN_SAMPLE = 1'b0;
  localparam logic FN_AUTOTUNE = 1'b1;

  typedef struct {
    logic                   fn;
    logic [1:0]             port;
    logic [3:0]             voice;
    logic signed [CV_W-1:0] cv;
    bit                     typed;
    logic signed [CV_W-1:0] res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  cddw_in_if in_ch();
  cddw_out_if out_ch();

  cv_detune_drift_walk_unit #(.POLY(POLY), .OUTS(OUTS)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  cfg_t m_cfg;
  logic signed [31:0] dt_pos[POLY];
  logic signed [15:0] dt_slp[POLY];
  logic signed [31:0] dr_pos[OUTS*POLY];
  logic signed [15:0] dr_slp[OUTS*POLY];
  bit [31:0] dt_events, dr_events, lfsr;

  logic signed [CV_W-1:0] cv_expected[$];
  int errors = 0;
  int cycles = 0;
  int accepted = 0;
  int send_idle = 30;
  int recv_idle = 63;
  bit hold_go = 0;
  bit hold_done = 0;
  int hold_left = 0;

  stim_row_t directed[] = '{
    '{FN_SAMPLE,   2'd0, 4'd0,  24'sh7FFFFF, 1, 24'sh7FFFFF},
    '{FN_SAMPLE,   2'd3, 4'd15, 24'sh800000, 1, 24'sh800000},
    '{FN_SAMPLE,   2'd1, 4'd5,  24'sh000000, 1, 24'sh000000},
    '{FN_SAMPLE,   2'd2, 4'd10, 24'shFFFFFF, 1, 24'shFFFFFF},
    '{FN_SAMPLE,   2'd0, 4'd15, 24'sh100000, 1, 24'sh100000},
    '{FN_SAMPLE,   2'd3, 4'd0,  24'shF00000, 1, 24'shF00000},
    '{FN_AUTOTUNE, 2'd3, 4'd15, 24'sh7FFFFF, 1, 24'sh000000},
    '{FN_SAMPLE,   2'd1, 4'd1,  24'sh555555, 1, 24'sh555555},
    '{FN_SAMPLE,   2'd2, 4'd14, 24'shAAAAAA, 1, 24'shAAAAAA},
    '{FN_AUTOTUNE, 2'd0, 4'd0,  24'sh000000, 1, 24'sh000000},
    '{FN_SAMPLE,   2'd3, 4'd7,  24'sh0F0F0F, 1, 24'sh0F0F0F},
    '{FN_SAMPLE,   2'd0, 4'd8,  24'shF0F0F0, 1, 24'shF0F0F0}
  };

  function automatic longint scale(bit [31:0] a, longint s, int sh);
    longint unsigned m;
    longint r;
    m = (s < 0) ? longint'(-s) : longint'(s);
    r = longint'(({32'd0, a} * m) >> sh);
    return (s < 0) ? -r : r;
  endfunction

  function automatic logic signed [15:0] draw_slope();
    bit sh_out;
    sh_out = lfsr[0];
    lfsr = lfsr >> 1;
    if (sh_out) lfsr = lfsr ^ LFSR_TAPS;
    return 16'(int'({17'd0, lfsr[14:0]}) - 16384);
  endfunction

  task automatic walk_reset();
    m_cfg = '{bypass: 1'b0, dt_gain: 16'd328, dr_gain: 16'd328, dt_step: 32'd973,
              dr_step: 32'd973, dt_period: 32'd2822400, dr_period: 32'd940800};
    foreach (dt_pos[i]) begin dt_pos[i] = '0; dt_slp[i] = '0; end
    foreach (dr_pos[i]) begin dr_pos[i] = '0; dr_slp[i] = '0; end
    dt_events = '0;
    dr_events = '0;
    lfsr = LFSR_SEED;
  endtask

  // returns 1 when the request yields a cv_out
  function automatic bit walk_step(logic fn, logic [1:0] port, logic [3:0] voice,
                                   logic signed [CV_W-1:0] cv,
                                   output logic signed [CV_W-1:0] res);
    int k;
    longint sum, dp, rp;
    res = cv;
    if (fn == FN_AUTOTUNE) begin
      foreach (dt_pos[i]) dt_pos[i] = '0;
      foreach (dr_pos[i]) dr_pos[i] = '0;
      return 0;
    end
    if (m_cfg.bypass || port >= OUTS || voice >= POLY) return 1;
    k = port * POLY + voice;
    sum = longint'(cv) + scale(m_cfg.dt_gain, dt_pos[voice], 26)
        + scale(m_cfg.dr_gain, dr_pos[k], 26);
    if (sum > 8388607) sum = 8388607;
    if (sum < -8388608) sum = -8388608;
    res = CV_W'(sum);
    dp = longint'(dt_pos[voice]) + scale(m_cfg.dt_step, dt_slp[voice], 16);
    if (dp > 64'sh40000000) begin
      dp = 64'sh40000000; dt_slp[voice] = SLP_MONE;
    end else if (dp < -64'sh40000000) begin
      dp = -64'sh40000000; dt_slp[voice] = SLP_ONE;
    end
    dt_pos[voice] = 32'(dp);
    rp = longint'(dr_pos[k]);
    if (rp > 64'sh40000000) begin
      rp = 64'sh40000000; dr_slp[k] = SLP_MONE;
    end else if (rp < -64'sh40000000) begin
      rp = -64'sh40000000; dr_slp[k] = SLP_ONE;
    end
    rp = rp + scale(m_cfg.dr_step, dr_slp[k], 16);
    dr_pos[k] = 32'(rp);
    dt_events = dt_events + 1;
    dr_events = dr_events + 1;
    if (dt_events > m_cfg.dt_period) begin
      dt_events = '0;
      for (int i = 0; i < POLY; i++) dt_slp[i] = draw_slope();
    end
    if (dr_events > m_cfg.dr_period) begin
      dr_events = '0;
      for (int i = 0; i < OUTS*POLY; i++) dr_slp[i] = draw_slope();
    end
    return 1;
  endfunction

  task automatic reg_write(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_BYPASS:    m_cfg.bypass = data[0];
      REG_DT_GAIN:   m_cfg.dt_gain = data[15:0];
      REG_DR_GAIN:   m_cfg.dr_gain = data[15:0];
      REG_DT_STEP:   m_cfg.dt_step = data;
      REG_DR_STEP:   m_cfg.dr_step = data;
      REG_DT_PERIOD: m_cfg.dt_period = data;
      REG_DR_PERIOD: m_cfg.dr_period = data;
      default: ;
    endcase
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    cfg_we <= 1'b0;
    @(posedge clk);
    while (cv_expected.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic load_setting(logic byp, logic [15:0] dtg, logic [15:0] drg,
                              logic [31:0] dts, logic [31:0] drs,
                              logic [31:0] dtp, logic [31:0] drp);
    drain();
    reg_write(REG_BYPASS, {31'd0, byp});
    reg_write(REG_DT_GAIN, {16'd0, dtg});
    reg_write(REG_DR_GAIN, {16'd0, drg});
    reg_write(REG_DT_STEP, dts);
    reg_write(REG_DR_STEP, drs);
    reg_write(REG_DT_PERIOD, dtp);
    reg_write(REG_DR_PERIOD, drp);
    cfg_we <= 1'b0;
  endtask

  task automatic send(logic fn, logic [1:0] port, logic [3:0] voice,
                      logic signed [CV_W-1:0] cv, bit typed, logic signed [CV_W-1:0] res);
    logic signed [CV_W-1:0] predicted;
    if (accepted < 430) begin
      send_idle = 30; recv_idle = 63;
    end else if (accepted < 860) begin
      send_idle = 63; recv_idle = 30;
    end else begin
      send_idle = 0; recv_idle = 0;
    end
    while ($urandom_range(0, 99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= fn;
    in_ch.out_port <= port;
    in_ch.voice_index <= voice;
    in_ch.cv_in <= cv;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    accepted++;
    if (walk_step(fn, port, voice, cv, predicted))
      cv_expected.push_back(typed ? res : predicted);
  endtask

  task automatic random_requests(int n);
    logic signed [CV_W-1:0] cv;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 7))
        0: cv = 24'sh7FFFFF;
        1: cv = 24'sh800000;
        default: cv = CV_W'($urandom);
      endcase
      send(($urandom_range(0, 99) < 3) ? FN_AUTOTUNE : FN_SAMPLE,
           2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)), cv, 0, '0);
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.func = FN_SAMPLE;
    in_ch.out_port = '0;
    in_ch.voice_index = '0;
    in_ch.cv_in = '0;
    walk_reset();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed[i])
      send(directed[i].fn, directed[i].port, directed[i].voice, directed[i].cv,
           directed[i].typed, directed[i].res);
    load_setting(1'b0, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'd0, 32'd0);
    random_requests(100);
    load_setting(1'b0, 16'd328, 16'd328, 32'h01000000, 32'h00800000, 32'd3, 32'd7);
    hold_go = 1;
    random_requests(300);
    load_setting(1'b1, 16'd5000, 16'd5000, 32'h10000000, 32'h10000000, 32'd2, 32'd2);
    random_requests(100);
    load_setting(1'b0, 16'($urandom), 16'($urandom), $urandom_range(0, 32'h0FFFFFFF),
                 $urandom_range(0, 32'h0FFFFFFF), $urandom_range(0, 50),
                 $urandom_range(0, 50));
    @(posedge clk);
    reg_write(REG_NONE, $urandom);
    cfg_we <= 1'b0;
    random_requests(300);
    load_setting(1'b0, 16'd0, 16'd0, 32'd0, 32'd0, 32'hFFFFFFFF, 32'hFFFFFFFF);
    random_requests(100);
    load_setting(1'b0, 16'd40000, 16'd40000, 32'h40000000, 32'h40000000, 32'd10,
                 32'd20);
    random_requests(400);
    drain();
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  always @(posedge clk) begin
    logic signed [CV_W-1:0] want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (cv_expected.size() == 0) begin
        errors++;
        $display("%0t unexpected cv_out: expected none, actual %0d", $time,
                 out_ch.cv_out);
      end else begin
        want = cv_expected.pop_front();
        if (out_ch.cv_out !== want) begin
          errors++;
          $display("%0t cv_out mismatch: expected %0d, actual %0d", $time, want,
                   out_ch.cv_out);
        end
      end
    end
    if (hold_go && !hold_done) begin
      hold_done = 1;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  initial out_ch.ready = 1'b0;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

endmodule

`default_nettype wire
